### hw/rtl/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg: text console cursor engine package
// Geometry, character and command codes, payload and control structs.
// ----------------------------------------------------------------------------
package tcc_pkg;

	localparam int COLUMNS   = 80;
	localparam int ROWS      = 25;
	localparam int TAB_WIDTH = 8;   // power of two: tab stop found by masking
	localparam int CELLS     = COLUMNS * ROWS;

	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int CELL_W = 11;
	localparam int WORD_W = 16;

	localparam logic [7:0] RESET_ATTR = 8'h0F;
	localparam logic [7:0] BLANK_CHAR = 8'h20;

	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;

	localparam logic [1:0] CMD_PUT   = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [7:0]        char_code;
		logic [CELL_W-1:0] cell_address;
	} req_t;

	typedef struct packed {
		logic [CELL_W-1:0] cursor_addr;
		logic [WORD_W-1:0] read_data;
	} rsp_t;

	// sequencer -> cursor
	typedef struct packed {
		logic put;
		logic home;
	} cur_ctl_t;

	// cursor -> sequencer
	typedef struct packed {
		logic              printable;
		logic              scroll;
		logic [CELL_W-1:0] cell_idx;
		logic [CELL_W-1:0] pos;
	} cur_info_t;

endpackage

### hw/rtl/tcc_cell_ram.sv
// ----------------------------------------------------------------------------
// tcc_cell_ram: screen cell store
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcc_cell_ram (
	input  logic                       clk,
	input  logic                       we,
	input  logic [tcc_pkg::CELL_W-1:0] waddr,
	input  logic [tcc_pkg::WORD_W-1:0] wdata,
	input  logic [tcc_pkg::CELL_W-1:0] raddr,
	output logic [tcc_pkg::WORD_W-1:0] rdata
);

	logic [tcc_pkg::WORD_W-1:0] mem [tcc_pkg::CELLS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/tcc_cursor.sv
// ----------------------------------------------------------------------------
// tcc_cursor: cursor position register and put-byte decode
// Works out the next column/row for a byte and flags a needed scroll.
// ----------------------------------------------------------------------------
module tcc_cursor (
	input  logic                clk,
	input  logic                arst_n,
	input  tcc_pkg::cur_ctl_t   ctl,
	input  logic [7:0]          char_code,
	output tcc_pkg::cur_info_t  info
);

	logic [tcc_pkg::COL_W-1:0] col_q;
	logic [tcc_pkg::ROW_W-1:0] row_q;

	logic [tcc_pkg::COL_W:0]   col_t;
	logic [tcc_pkg::ROW_W:0]   row_t;
	logic [tcc_pkg::COL_W-1:0] col_n;
	logic [tcc_pkg::ROW_W-1:0] row_n;
	logic                      printable;
	logic                      scroll;

	assign printable = !char_code[7] && (char_code[6:5] != 2'b00);

	always_comb begin
		col_t = {1'b0, col_q};
		row_t = {1'b0, row_q};
		case (char_code)
			tcc_pkg::CH_BS: begin
				if (col_q != '0) col_t = {1'b0, col_q} - 1'b1;
			end
			tcc_pkg::CH_TAB: begin
				col_t = ({1'b0, col_q} | (tcc_pkg::COL_W+1)'(tcc_pkg::TAB_WIDTH - 1)) + 1'b1;
			end
			tcc_pkg::CH_CR: begin
				col_t = '0;
			end
			tcc_pkg::CH_LF: begin
				col_t = '0;
				row_t = {1'b0, row_q} + 1'b1;
			end
			default: begin
				if (printable) col_t = {1'b0, col_q} + 1'b1;
			end
		endcase
		if (col_t >= (tcc_pkg::COL_W+1)'(tcc_pkg::COLUMNS)) begin
			col_t = '0;
			row_t = row_t + 1'b1;
		end
		scroll = (row_t >= (tcc_pkg::ROW_W+1)'(tcc_pkg::ROWS));
		col_n  = col_t[tcc_pkg::COL_W-1:0];
		row_n  = scroll ? tcc_pkg::ROW_W'(tcc_pkg::ROWS - 1) : row_t[tcc_pkg::ROW_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (ctl.home) begin
			col_q <= '0;
			row_q <= '0;
		end else if (ctl.put) begin
			col_q <= col_n;
			row_q <= row_n;
		end
	end

	always_comb begin
		info.printable = printable;
		info.scroll    = scroll;
		info.cell_idx  = tcc_pkg::CELL_W'(row_q) * tcc_pkg::CELL_W'(tcc_pkg::COLUMNS)
		                 + tcc_pkg::CELL_W'(col_q);
		info.pos       = info.cell_idx;
	end

endmodule

### hw/rtl/tcc_seq.sv
// ----------------------------------------------------------------------------
// tcc_seq: command sequencer
// Drives the cell store for put, read, clear, scroll copy and reset fill.
// ----------------------------------------------------------------------------
module tcc_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  tcc_pkg::req_t              request,
	input  logic [7:0]                 attr,
	input  tcc_pkg::cur_info_t         cur,
	output tcc_pkg::cur_ctl_t          cur_ctl,
	output logic                       busy,
	output logic                       done,
	output logic [tcc_pkg::WORD_W-1:0] read_data,
	output logic                       ram_we,
	output logic [tcc_pkg::CELL_W-1:0] ram_waddr,
	output logic [tcc_pkg::WORD_W-1:0] ram_wdata,
	output logic [tcc_pkg::CELL_W-1:0] ram_raddr,
	input  logic [tcc_pkg::WORD_W-1:0] ram_rdata
);

	typedef enum logic [5:0] {
		ST_INIT   = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_READ   = 6'b000100,
		ST_FILL   = 6'b001000,
		ST_SCROLL = 6'b010000,
		ST_BLANK  = 6'b100000
	} state_t;

	localparam logic [tcc_pkg::CELL_W-1:0] LAST_CELL = tcc_pkg::CELL_W'(tcc_pkg::CELLS - 1);
	localparam logic [tcc_pkg::CELL_W-1:0] END_CELL  = tcc_pkg::CELL_W'(tcc_pkg::CELLS);
	localparam logic [tcc_pkg::CELL_W-1:0] ROW_LEN   = tcc_pkg::CELL_W'(tcc_pkg::COLUMNS);

	state_t                     state_q;
	logic [tcc_pkg::CELL_W-1:0] ptr_q;
	logic                       copy_s1;
	logic [tcc_pkg::CELL_W-1:0] dst_s1;
	logic                       done_q;
	logic [tcc_pkg::WORD_W-1:0] data_q;
	logic                       rd_ok_q;
	logic                       accept;
	logic [tcc_pkg::WORD_W-1:0] blank;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign blank  = {attr, tcc_pkg::BLANK_CHAR};

	assign cur_ctl.put  = accept && (request.cmd == tcc_pkg::CMD_PUT);
	assign cur_ctl.home = accept && (request.cmd == tcc_pkg::CMD_CLEAR);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_q;
		ram_wdata = blank;
		ram_raddr = request.cell_address;
		unique case (state_q)
			ST_INIT: begin
				// reset pass uses the reset attribute, whatever was written meanwhile
				ram_we    = 1'b1;
				ram_wdata = {tcc_pkg::RESET_ATTR, tcc_pkg::BLANK_CHAR};
			end
			ST_IDLE: begin
				if (cur_ctl.put && cur.printable) begin
					ram_we    = 1'b1;
					ram_waddr = cur.cell_idx;
					ram_wdata = {attr, request.char_code};
				end
			end
			ST_FILL, ST_BLANK: begin
				ram_we = 1'b1;
			end
			ST_SCROLL: begin
				// read one row ahead, write back the word read last cycle
				ram_raddr = ptr_q;
				ram_we    = copy_s1;
				ram_waddr = dst_s1;
				ram_wdata = ram_rdata;
			end
			ST_READ: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			ptr_q   <= '0;
			copy_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q  <= 1'b0;
			copy_s1 <= 1'b0;
			unique case (state_q)
				ST_INIT: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == LAST_CELL) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						case (request.cmd)
							tcc_pkg::CMD_PUT: begin
								if (cur.scroll) begin
									state_q <= ST_SCROLL;
									ptr_q   <= ROW_LEN;
								end else begin
									done_q <= 1'b1;
								end
							end
							tcc_pkg::CMD_CLEAR: begin
								state_q <= ST_FILL;
								ptr_q   <= '0;
							end
							tcc_pkg::CMD_READ: begin
								state_q <= ST_READ;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_READ: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_FILL, ST_BLANK: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == LAST_CELL) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_SCROLL: begin
					if (ptr_q == END_CELL) begin
						state_q <= ST_BLANK;
						ptr_q   <= END_CELL - ROW_LEN;
					end else begin
						copy_s1 <= 1'b1;
						ptr_q   <= ptr_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		dst_s1 <= ptr_q - ROW_LEN;
		if (state_q == ST_IDLE) begin
			rd_ok_q <= (request.cell_address < END_CELL);
			data_q  <= '0;
		end else if (state_q == ST_READ) begin
			data_q <= rd_ok_q ? ram_rdata : '0;
		end else begin
			data_q <= '0;
		end
	end

	assign done      = done_q;
	assign read_data = data_q;

	// a plain put that needs no scroll finishes in the next cycle
	a_put_done: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && request.cmd == tcc_pkg::CMD_PUT && !cur.scroll) |=> done)
		else $error("put without scroll did not finish in one cycle");

	// a read passes through ST_READ with done low before its word is delivered
	a_read_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && request.cmd == tcc_pkg::CMD_READ) |=> !done ##1 done)
		else $error("read latency broken");

	// pending copy writes only exist inside the scroll copy
	a_copy_scope: assert property (@(posedge clk) disable iff (!arst_n)
		copy_s1 |-> (state_q == ST_SCROLL))
		else $error("copy write outside scroll");

	// the reset fill produces no word
	a_init_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INIT) |=> !done)
		else $error("word produced during reset fill");

	// copy never writes a word whose source cell has not yet been read
	a_copy_order: assert property (@(posedge clk) disable iff (!arst_n)
		copy_s1 |-> (dst_s1 + ROW_LEN < ptr_q))
		else $error("scroll copy overtook its source");

endmodule

### hw/rtl/text_console_cursor_engine.sv
// ----------------------------------------------------------------------------
// text_console_cursor_engine: 80x25 text console with cursor
// Cell store of attribute/character words, put, clear and read commands.
// ----------------------------------------------------------------------------
// Usage:
//   A command word on request is taken at a clock edge with start high and
//   busy low. Each command gives exactly one result word on result, valid for
//   the single cycle in which done is high; the receiver cannot stall.
//   cursor_addr is the linear cursor position after the command; read_data is
//   the addressed cell for a read of an address below 2000, else 0.
//   A put that needs no scroll stays in the idle state; a read waits in the
//   read state for the registered cell word; a clear writes one cell per
//   cycle through the store's single write port; a put that scrolls copies
//   1920 cells one per cycle, then blanks the 80 bottom cells. Puts go one
//   per cycle while no scroll is needed; busy stays low only in the idle state.
//   cfg_we/cfg_data write the text attribute in any cycle.
//   After reset busy stays high while the store is filled with
//   blank cells of attribute 0x0F; the cursor resets to the home position.
// ----------------------------------------------------------------------------
module text_console_cursor_engine (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  tcc_pkg::req_t  request,
	output logic           done,
	output tcc_pkg::rsp_t  result,
	input  logic           cfg_we,
	input  logic [7:0]     cfg_data
);

	logic [7:0]                 attr_q;
	tcc_pkg::cur_ctl_t          cur_ctl;
	tcc_pkg::cur_info_t         cur;
	logic [tcc_pkg::WORD_W-1:0] read_data;
	logic                       ram_we;
	logic [tcc_pkg::CELL_W-1:0] ram_waddr;
	logic [tcc_pkg::WORD_W-1:0] ram_wdata;
	logic [tcc_pkg::CELL_W-1:0] ram_raddr;
	logic [tcc_pkg::WORD_W-1:0] ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tcc_pkg::RESET_ATTR;
		end else if (cfg_we) begin
			attr_q <= cfg_data;
		end
	end

	tcc_cursor u_cursor (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (cur_ctl),
		.char_code (request.char_code),
		.info      (cur)
	);

	tcc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.request   (request),
		.attr      (attr_q),
		.cur       (cur),
		.cur_ctl   (cur_ctl),
		.busy      (busy),
		.done      (done),
		.read_data (read_data),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	tcc_cell_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// cursor registers change only at an accept, so they hold the
	// post-command position throughout the done cycle
	assign result.cursor_addr = cur.pos;
	assign result.read_data   = read_data;

endmodule
